// ===== rtl/assert_macros.svh =====
// assertion macros for the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// condition must never be seen on a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/asid_pkg.sv =====
// types, constants and codes of the address-space id allocator
`default_nettype none

package asid_pkg;

    localparam int ID_CAPACITY   = 4096;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_DEPTH     = (ID_CAPACITY + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
    localparam int WORD_IDX_W    = $clog2(MAP_DEPTH);
    localparam int ID_W          = 12;
    localparam int CNT_W         = 13;

    localparam logic [ID_W-1:0] SHARED_ID    = 12'd0;
    localparam logic [ID_W-1:0] KERNEL_ID    = 12'd1;
    localparam logic [ID_W-1:0] USER_ID_BASE = 12'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE_FREE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE  = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef logic [MAP_WORD_BITS-1:0] word_t;
    typedef logic [WORD_IDX_W-1:0]    word_idx_t;
    typedef logic [BIT_IDX_W-1:0]     bit_idx_t;
    typedef logic [ID_W-1:0]          id_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef struct packed {
        logic      en;
        word_idx_t addr;
    } map_rd_t;

    typedef struct packed {
        logic      en;
        word_idx_t addr;
        word_t     data;
    } map_wr_t;

    typedef struct packed {
        logic     hit;
        bit_idx_t bit_idx;
    } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/asid_map.sv =====
// used-id bitmap memory with per-row valid bits and registered read
`default_nettype none

module asid_map (
    input  wire              clk,
    input  wire              rst_n,
    input  asid_pkg::map_rd_t rd_req,
    input  asid_pkg::map_wr_t wr_req,
    output asid_pkg::word_t   rd_data
);
    import asid_pkg::*;

    word_t                mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] row_valid_reg;
    word_t                data_reg;
    word_idx_t            addr_reg;
    logic                 valid_reg;
    word_t                row0_reset;

    always_comb
    begin
        row0_reset = '0;
        row0_reset[SHARED_ID[BIT_IDX_W-1:0]] = 1'b1;
        row0_reset[KERNEL_ID[BIT_IDX_W-1:0]] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            data_reg <= mem[rd_req.addr];
            addr_reg <= rd_req.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (wr_req.en)
            begin
                row_valid_reg[wr_req.addr] <= 1'b1;
            end
            if (rd_req.en)
            begin
                valid_reg <= row_valid_reg[rd_req.addr];
            end
        end
    end

    assign rd_data = valid_reg ? data_reg :
                     ((addr_reg == '0) ? row0_reset : '0);

endmodule

`default_nettype wire

// ===== rtl/asid_scan.sv =====
// masks one bitmap word to the legal id range and finds its lowest free bit
`default_nettype none

module asid_scan (
    input  asid_pkg::word_t     word,
    input  asid_pkg::word_idx_t word_idx,
    input  asid_pkg::word_idx_t last_word,
    input  asid_pkg::bit_idx_t  last_bit,
    output asid_pkg::scan_res_t res,
    output asid_pkg::word_t     onehot
);
    import asid_pkg::*;

    word_t    mask;
    word_t    avail;
    bit_idx_t enc;

    always_comb
    begin
        if (word_idx == last_word)
        begin
            mask = {MAP_WORD_BITS{1'b1}} >> ((MAP_WORD_BITS - 1) - int'(last_bit));
        end
        else
        begin
            mask = {MAP_WORD_BITS{1'b1}};
        end
        if (word_idx == '0)
        begin
            mask[SHARED_ID[BIT_IDX_W-1:0]] = 1'b0;
            mask[KERNEL_ID[BIT_IDX_W-1:0]] = 1'b0;
        end
    end

    assign avail  = ~word & mask;
    assign onehot = avail & (~avail + word_t'(1));

    always_comb
    begin
        for (int k = 0; k < BIT_IDX_W; k++)
        begin
            enc[k] = 1'b0;
            for (int b = 0; b < MAP_WORD_BITS; b++)
            begin
                if (((b >> k) & 1) == 1)
                begin
                    enc[k] = enc[k] | onehot[b];
                end
            end
        end
    end

    assign res.hit     = |avail;
    assign res.bit_idx = enc;

endmodule

`default_nettype wire

// ===== rtl/address_space_id_allocator.sv =====
// address-space id allocator: request sequencer, bitmap and word scanner
//
// one transfer in on s_*: s_tuser is the mode (0 allocate, 1 free),
// s_tdata[11:0] the id to free; one result transfer out on m_*:
// m_tdata[11:0] the granted id (0 when none or on free), m_tuser the
// status (0 ok, 1 none free, 2 invalid free).
// cfg_we/cfg_data write the id count; values above 4096 act as 4096.
// an allocate walks the bitmap one 64-bit word per cycle through a single
// read port and one shared mask/find-first unit, scanning up to 64 words.
// a free reads one word and writes it back with the id's bit cleared.
// requests rejected up front (small count, invalid free) go straight to
// the done step without touching the bitmap.
// s_tready is high only while no request is in work; the result sits in
// an output register, so a new request is taken while it waits on m_tready.
// a stalled result holds the sequencer in its done step until it moves.
// reset marks ids 0 and 1 used, all others free, at once through per-row
// valid bits; the count resets to 4096.
`default_nettype none

`include "assert_macros.svh"

module address_space_id_allocator (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,   // free_id[11:0], zero pad
    input  wire        s_tuser,   // mode
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata,  // granted_id[11:0], zero pad
    output logic [1:0] m_tuser,   // status
    input  wire        cfg_we,
    input  wire [12:0] cfg_data   // id_count
);
    import asid_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    cnt_t       id_count_reg;
    word_idx_t  chk_w_reg, chk_w_next;
    id_t        fid_reg, fid_next;
    id_t        res_id_reg, res_id_next;
    logic [1:0] res_st_reg, res_st_next;
    logic       out_valid_reg, out_valid_next;
    id_t        out_id_reg, out_id_next;
    logic [1:0] out_st_reg, out_st_next;

    cnt_t      cnt_eff;
    cnt_t      cnt_m1;
    word_idx_t last_word;
    bit_idx_t  last_bit;
    logic      accept;
    logic      free_ok;
    id_t       in_fid;
    map_rd_t   rd_req;
    map_wr_t   wr_req;
    word_t     rd_data;
    scan_res_t scan_res;
    word_t     scan_onehot;

    asid_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (rd_data)
    );

    asid_scan u_scan (
        .word      (rd_data),
        .word_idx  (chk_w_reg),
        .last_word (last_word),
        .last_bit  (last_bit),
        .res       (scan_res),
        .onehot    (scan_onehot)
    );

    assign cnt_eff   = (id_count_reg > CNT_W'(ID_CAPACITY)) ? CNT_W'(ID_CAPACITY)
                                                            : id_count_reg;
    assign cnt_m1    = cnt_eff - cnt_t'(1);
    assign last_word = cnt_m1[ID_W-1:BIT_IDX_W];
    assign last_bit  = cnt_m1[BIT_IDX_W-1:0];
    assign in_fid    = s_tdata[ID_W-1:0];
    assign free_ok   = (in_fid >= USER_ID_BASE) && ({1'b0, in_fid} < cnt_eff);
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        chk_w_next     = chk_w_reg;
        fid_next       = fid_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_st_next    = out_st_reg;
        rd_req.en      = 1'b0;
        rd_req.addr    = chk_w_reg + word_idx_t'(1);
        wr_req.en      = 1'b0;
        wr_req.addr    = chk_w_reg;
        wr_req.data    = rd_data | scan_onehot;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fid_next = in_fid;
                    if (s_tuser == MODE_ALLOC)
                    begin
                        if (cnt_eff > {1'b0, USER_ID_BASE})
                        begin
                            rd_req.en   = 1'b1;
                            rd_req.addr = '0;
                            chk_w_next  = '0;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            res_id_next = '0;
                            res_st_next = ST_NONE_FREE;
                            state_next  = S_DONE;
                        end
                    end
                    else if (free_ok)
                    begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = in_fid[ID_W-1:BIT_IDX_W];
                        state_next  = S_FREE;
                    end
                    else
                    begin
                        res_id_next = '0;
                        res_st_next = ST_BAD_FREE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                rd_req.en = 1'b1;
                if (scan_res.hit)
                begin
                    wr_req.en   = 1'b1;
                    res_id_next = {chk_w_reg, scan_res.bit_idx};
                    res_st_next = ST_OK;
                    state_next  = S_DONE;
                end
                else if (chk_w_reg == last_word)
                begin
                    res_id_next = '0;
                    res_st_next = ST_NONE_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    chk_w_next = chk_w_reg + word_idx_t'(1);
                end
            end
            S_FREE:
            begin
                wr_req.en   = 1'b1;
                wr_req.addr = fid_reg[ID_W-1:BIT_IDX_W];
                wr_req.data = rd_data & ~(word_t'(1) << fid_reg[BIT_IDX_W-1:0]);
                res_id_next = '0;
                res_st_next = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            id_count_reg  <= CNT_W'(ID_CAPACITY);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                id_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_w_reg  <= chk_w_next;
        fid_reg    <= fid_next;
        res_id_reg <= res_id_next;
        res_st_reg <= res_st_next;
        out_id_reg <= out_id_next;
        out_st_reg <= out_st_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - ID_W){1'b0}}, out_id_reg};
    assign m_tuser  = out_st_reg;

    `ASSERT_CLK(a_none_free_zero, clk, rst_n,
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[ID_W-1:0] == '0))
    `ASSERT_CLK(a_grant_in_range, clk, rst_n,
        (m_tvalid && (m_tdata[ID_W-1:0] != '0)) |->
        ((m_tdata[ID_W-1:0] >= USER_ID_BASE) && ({1'b0, m_tdata[ID_W-1:0]} < cnt_eff)))
    `ASSERT_CLK(a_scan_bounded, clk, rst_n,
        (state_reg == S_SCAN) |-> (chk_w_reg <= last_word))
    `ASSERT_NEVER(a_rw_collide, clk, rst_n,
        wr_req.en && rd_req.en && (wr_req.addr == rd_req.addr))

endmodule

`default_nettype wire
